// ===== hdl/c2p_pkg.sv =====
// Shared types and constants for the CORDIC cartesian-to-polar pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package c2p_pkg;

    // Q3.12 code of pi/2 and Q1.13 code of the CORDIC gain correction
    localparam logic signed [14:0] HALF_PI_Q12  = 15'sd6433;
    localparam logic signed [13:0] GAIN_Q13     = 14'sd4974;
    localparam int                 ATAN_ENTRIES = 20;

    // Working state of one point as it moves down the pipeline
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [14:0] ang;
    } t_beat;

    // atan(2^-idx) in Q3.12, rounded down; zero past the end of the table
    function automatic logic signed [14:0] atan_q12(input int idx);
        logic signed [14:0] v;
        case (idx)
            0:       v = 15'sd3216;
            1:       v = 15'sd1899;
            2:       v = 15'sd1003;
            3:       v = 15'sd509;
            4:       v = 15'sd255;
            5:       v = 15'sd127;
            6:       v = 15'sd63;
            7:       v = 15'sd31;
            8:       v = 15'sd15;
            9:       v = 15'sd7;
            10:      v = 15'sd3;
            11:      v = 15'sd1;
            default: v = 15'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/cordic_cartesian_to_polar_top.sv =====
// Top level of the CORDIC cartesian-to-polar converter.
// Depends on c2p_pkg, c2p_prerot, c2p_stage and c2p_gain.
`default_nettype none

// Converts a point (x, y) in signed Q3.13 to magnitude (Q3.13) and angle in
// radians (Q3.12). The pipeline has one slot for the +/- pi/2 pre-rotation,
// one slot per micro-rotation (ITERATIONS of them) and one slot for the gain
// multiply; a new beat can be taken every cycle unless the output is held
// back with a full pipe. Each slot has its own valid bit and moves whenever
// the slot after it is empty or emptying, so bubbles squeeze out while the
// output is held back.
module cordic_cartesian_to_polar_top
    import c2p_pkg::*;
#(
    parameter int ITERATIONS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [15:0] x_coord, [31:16] y_coord
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // [15:0] magnitude, [30:16] angle, [31] zero
);

    t_beat              beat  [0:ITERATIONS];
    logic               valid [0:ITERATIONS];
    logic               ready [0:ITERATIONS+1];
    logic signed [15:0] mag;
    logic signed [14:0] ang;

    // pre-rotation slot
    c2p_prerot u_prerot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_x     (s_axis_tdata[15:0]),
        .i_y     (s_axis_tdata[31:16]),
        .o_ready (ready[0]),
        .i_ready (ready[1]),
        .o_valid (valid[0]),
        .o_beat  (beat[0])
    );

    assign s_axis_tready = ready[0];

    // micro-rotation slots
    for (genvar k = 0; k < ITERATIONS; k++) begin : g_stage
        c2p_stage #(
            .SHIFT (k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid[k]),
            .i_beat  (beat[k]),
            .o_ready (ready[k+1]),
            .i_ready (ready[k+2]),
            .o_valid (valid[k+1]),
            .o_beat  (beat[k+1])
        );
    end

    // gain multiply and output slot
    c2p_gain u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (valid[ITERATIONS]),
        .i_beat  (beat[ITERATIONS]),
        .o_ready (ready[ITERATIONS+1]),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_mag   (mag),
        .o_ang   (ang)
    );

    assign m_axis_tdata = {1'b0, ang, mag};

    // no result beat right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

    // input only backs up when the whole pipe is full behind a stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && valid[0]))
        else $error("input stalled without a full pipe");

    // pre-rotation leaves x non-negative except for the wrapped -32768 case
    a_prerot_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        valid[0] |-> (!beat[0].x[15] || beat[0].x == 16'sh8000))
        else $error("pre-rotation produced negative x");

endmodule

`default_nettype wire

// ===== hdl/c2p_prerot.sv =====
// First pipeline slot: rotates the input point by +/- pi/2 into the right half plane.
// Depends on c2p_pkg.
`default_nettype none

module c2p_prerot
    import c2p_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic signed [15:0] i_x,
    input  wire logic signed [15:0] i_y,
    output logic                    o_ready,
    input  wire logic               i_ready,
    output logic                    o_valid,
    output t_beat                   o_beat
);

    logic  r_valid;
    t_beat r_beat;
    t_beat n_beat;

    // slot takes a beat when empty or when its content moves on
    assign o_ready = !r_valid || i_ready;

    // y >= 0 turns by -pi/2, y < 0 by +pi/2; negation wraps to 16 bits
    always_comb begin
        if (!i_y[15]) begin
            n_beat.x   = i_y;
            n_beat.y   = -i_x;
            n_beat.ang = HALF_PI_Q12;
        end else begin
            n_beat.x   = -i_y;
            n_beat.y   = i_x;
            n_beat.ang = -HALF_PI_Q12;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

`default_nettype wire

// ===== hdl/c2p_stage.sv =====
// One CORDIC vectoring micro-rotation as a registered pipeline slot.
// Depends on c2p_pkg; SHIFT selects the shift amount and arctangent entry.
`default_nettype none

module c2p_stage
    import c2p_pkg::*;
#(
    parameter int SHIFT = 0
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_beat i_beat,
    output logic       o_ready,
    input  wire logic  i_ready,
    output logic       o_valid,
    output t_beat      o_beat
);

    localparam logic signed [14:0] ATAN_STEP = atan_q12(SHIFT);

    logic               r_valid;
    t_beat              r_beat;
    t_beat              n_beat;
    logic signed [15:0] xs;
    logic signed [15:0] ys;

    assign o_ready = !r_valid || i_ready;

    // arithmetic shifts, bits shifted out are dropped
    assign xs = i_beat.x >>> SHIFT;
    assign ys = i_beat.y >>> SHIFT;

    // steer toward y = 0; all sums wrap
    always_comb begin
        if (!i_beat.y[15]) begin
            n_beat.x   = i_beat.x + ys;
            n_beat.y   = i_beat.y - xs;
            n_beat.ang = i_beat.ang + ATAN_STEP;
        end else begin
            n_beat.x   = i_beat.x - ys;
            n_beat.y   = i_beat.y + xs;
            n_beat.ang = i_beat.ang - ATAN_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

`default_nettype wire

// ===== hdl/c2p_gain.sv =====
// Output slot: scales the final x by the CORDIC gain and holds the result beat.
// Depends on c2p_pkg.
`default_nettype none

module c2p_gain
    import c2p_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire t_beat              i_beat,
    output logic                    o_ready,
    input  wire logic               i_ready,
    output logic                    o_valid,
    output logic signed [15:0]      o_mag,
    output logic signed [14:0]      o_ang
);

    logic               r_valid;
    logic signed [15:0] r_mag;
    logic signed [14:0] r_ang;
    logic signed [29:0] prod;

    assign o_ready = !r_valid || i_ready;

    // 16 x 14 signed product; drop 13 fraction bits, keep 16 (wraps)
    assign prod = 30'(i_beat.x) * 30'(GAIN_Q13);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mag <= prod[28:13];
            r_ang <= i_beat.ang;
        end
    end

    assign o_valid = r_valid;
    assign o_mag   = r_mag;
    assign o_ang   = r_ang;

endmodule

`default_nettype wire
